// ===== hw/rtl/command_frame_checker_macros.svh =====
// ----------------------------------------------------------------------------
// command frame checker assertion macros
// shared assertion forms for the checker, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_CHECKER_MACROS_SVH
`define COMMAND_FRAME_CHECKER_MACROS_SVH

// property checked on every rising edge of clk_i while out of reset
`define CFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form, antecedent and consequent given apart
`define CFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// types and constants of the command frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned CODE_N = 4;

  localparam logic [BYTE_W-1:0] START_MARK     = 8'hFF;
  localparam logic [BYTE_W-1:0] WRITE_KIND     = 8'h06;
  localparam logic [BYTE_W-1:0] TYPE_SET_CODE  = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_OPEN_DOOR = 8'h03;
  localparam logic [BYTE_W-1:0] OWN_ID_RESET   = 8'h02;
  localparam logic [POS_W-1:0]  FRAME_OVERHEAD = 9'd6;

  // byte positions within a frame
  localparam logic [POS_W-1:0] POS_START  = 9'd0;
  localparam logic [POS_W-1:0] POS_DEVICE = 9'd1;
  localparam logic [POS_W-1:0] POS_TYPE   = 9'd2;
  localparam logic [POS_W-1:0] POS_KIND   = 9'd3;
  localparam logic [POS_W-1:0] POS_LEN    = 9'd4;
  localparam logic [POS_W-1:0] POS_CODE   = 9'd5;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_START  = 2'd1,
    ST_BAD_DEVICE = 2'd2,
    ST_BAD_SUM    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_SET_CODE  = 2'd1,
    ACT_OPEN_DOOR = 2'd2
  } action_e;

  typedef struct packed {
    status_e                       status;
    action_e                       action;
    logic [CODE_N-1:0][BYTE_W-1:0] code;
  } result_t;

endpackage

// ===== hw/rtl/command_frame_checker.sv =====
// ----------------------------------------------------------------------------
// command_frame_checker
// checks received command frames byte by byte and reports one result per frame
// ----------------------------------------------------------------------------
// a frame's last byte is held in the input register, and its result is then held in the result register
// throughput: one byte per cycle while the input register does not stall, set by the frame state update
// the input register stalls only while a frame-ending byte waits on a full
// and stalled result register
// reset clears all frame state and sets the device id register to 2
`timescale 1ns / 1ps

module command_frame_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cfc_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [cfc_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [1:0]                 action_o,
  output logic [cfc_pkg::BYTE_W-1:0] code_byte0_o,
  output logic [cfc_pkg::BYTE_W-1:0] code_byte1_o,
  output logic [cfc_pkg::BYTE_W-1:0] code_byte2_o,
  output logic [cfc_pkg::BYTE_W-1:0] code_byte3_o
);

  logic [cfc_pkg::BYTE_W-1:0] own_id_q;
  logic                       s1_valid;
  logic [cfc_pkg::BYTE_W-1:0] s1_byte;
  logic                       take;
  logic                       done;
  logic                       out_free;
  cfc_pkg::result_t           res;
  cfc_pkg::result_t           res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= cfc_pkg::OWN_ID_RESET;
    end else if (cfg_we_i) begin
      own_id_q <= cfg_wdata_i;
    end
  end

  // a byte that ends a frame needs room in the result register
  assign take = s1_valid && (!done || out_free);

  cfc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  cfc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .own_id_i (own_id_q),
    .byte_i   (s1_byte),
    .en_i     (take),
    .done_o   (done),
    .res_o    (res)
  );

  cfc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && done),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign status_o     = res_out.status;
  assign action_o     = res_out.action;
  assign code_byte0_o = res_out.code[0];
  assign code_byte1_o = res_out.code[1];
  assign code_byte2_o = res_out.code[2];
  assign code_byte3_o = res_out.code[3];

endmodule

// ===== hw/rtl/cfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// cfc_in_reg
// input register, holds one received byte until the frame stage takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cfc_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [cfc_pkg::BYTE_W-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [cfc_pkg::BYTE_W-1:0] byte_q;

  assign in_stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/cfc_frame.sv =====
// ----------------------------------------------------------------------------
// cfc_frame
// frame tracking state, checksum and end-of-frame result logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_frame (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cfc_pkg::BYTE_W-1:0] own_id_i,
  input  logic [cfc_pkg::BYTE_W-1:0] byte_i,
  input  logic                       en_i,
  output logic                       done_o,
  output cfc_pkg::result_t           res_o
);

  logic [cfc_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [cfc_pkg::POS_W-1:0]  len_q, len_d;
  logic [cfc_pkg::BYTE_W-1:0] sum_q, sum_d;
  logic                       start_ok_q, start_ok_d;
  logic                       dev_ok_q, dev_ok_d;
  logic [cfc_pkg::BYTE_W-1:0] type_q, type_d;
  logic [cfc_pkg::BYTE_W-1:0] kind_q, kind_d;
  logic [cfc_pkg::CODE_N-1:0][cfc_pkg::BYTE_W-1:0] code_q, code_d, code_now;
  logic [cfc_pkg::POS_W-1:0]  count;

  assign count  = pos_q + 9'd1;
  assign done_o = (pos_q >= cfc_pkg::POS_CODE) && (count == len_q);

  always_comb begin
    for (int k = 0; k < cfc_pkg::CODE_N; k++) begin
      code_now[k] = (pos_q == cfc_pkg::POS_CODE + cfc_pkg::POS_W'(k)) ? byte_i : code_q[k];
    end
  end

  always_comb begin
    res_o.code   = code_now;
    res_o.action = cfc_pkg::ACT_NONE;
    if (!start_ok_q) begin
      res_o.status = cfc_pkg::ST_BAD_START;
    end else if (!dev_ok_q) begin
      res_o.status = cfc_pkg::ST_BAD_DEVICE;
    end else if (sum_q != byte_i) begin
      res_o.status = cfc_pkg::ST_BAD_SUM;
    end else begin
      res_o.status = cfc_pkg::ST_OK;
      if (kind_q == cfc_pkg::WRITE_KIND) begin
        if (type_q == cfc_pkg::TYPE_SET_CODE) begin
          res_o.action = cfc_pkg::ACT_SET_CODE;
        end else if (type_q == cfc_pkg::TYPE_OPEN_DOOR) begin
          res_o.action = cfc_pkg::ACT_OPEN_DOOR;
        end
      end
    end
  end

  always_comb begin
    pos_d      = pos_q;
    len_d      = len_q;
    sum_d      = sum_q;
    start_ok_d = start_ok_q;
    dev_ok_d   = dev_ok_q;
    type_d     = type_q;
    kind_d     = kind_q;
    code_d     = code_q;
    if (en_i) begin
      if (done_o) begin
        pos_d      = '0;
        len_d      = '0;
        sum_d      = '0;
        start_ok_d = 1'b0;
        dev_ok_d   = 1'b0;
        type_d     = '0;
        kind_d     = '0;
        code_d     = '0;
      end else begin
        pos_d  = count;
        sum_d  = sum_q + byte_i;
        code_d = code_now;
        case (pos_q)
          cfc_pkg::POS_START:  start_ok_d = (byte_i == cfc_pkg::START_MARK);
          cfc_pkg::POS_DEVICE: dev_ok_d   = (byte_i == own_id_i);
          cfc_pkg::POS_TYPE:   type_d     = byte_i;
          cfc_pkg::POS_KIND:   kind_d     = byte_i;
          cfc_pkg::POS_LEN:    len_d      = {1'b0, byte_i} + cfc_pkg::FRAME_OVERHEAD;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      start_ok_q <= 1'b0;
      dev_ok_q   <= 1'b0;
      type_q     <= '0;
      kind_q     <= '0;
      code_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      start_ok_q <= start_ok_d;
      dev_ok_q   <= dev_ok_d;
      type_q     <= type_d;
      kind_q     <= kind_d;
      code_q     <= code_d;
    end
  end

endmodule

// ===== hw/rtl/cfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfc_out_reg
// result register, holds a finished result until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cfc_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfc_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  cfc_pkg::result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/cfc_checker.sv =====
// ----------------------------------------------------------------------------
// cfc_checker
// port-level assertions for the command frame checker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_frame_checker_macros.svh"

module cfc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic [1:0]                 action_o,
  input logic [cfc_pkg::BYTE_W-1:0] code_byte0_o,
  input logic [cfc_pkg::BYTE_W-1:0] code_byte1_o,
  input logic [cfc_pkg::BYTE_W-1:0] code_byte2_o,
  input logic [cfc_pkg::BYTE_W-1:0] code_byte3_o
);

  // an action is only reported for a frame that passed every check
  `CFC_ASSERT_IMP(a_action_needs_ok,
                  out_valid_o && (action_o != cfc_pkg::ACT_NONE),
                  status_o == cfc_pkg::ST_OK, "action on failed frame")

  // a new result must follow the transfer of its last byte on the input
  `CFC_ASSERT_IMP(a_result_latency, $rose(out_valid_o),
                  $past(in_valid_i && !in_stall_o, 2), "result without matching transfer")

  // a stalled result stays offered
  `CFC_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")

  // a stalled result keeps its payload
  `CFC_ASSERT(a_out_payload_hold,
              out_valid_o && out_stall_i |=> $stable(status_o) && $stable(action_o) &&
              $stable(code_byte0_o) && $stable(code_byte1_o) &&
              $stable(code_byte2_o) && $stable(code_byte3_o),
              "result changed")

endmodule

bind command_frame_checker cfc_checker u_cfc_checker (.*);
